[rtl/lksc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_pkg
// Shared request codes and controller/datapath signal groups for the LRU
// keyed slot cache directory.
// ----------------------------------------------------------------------------
package lksc_pkg;

    localparam int KeyW = 32;
    localparam int SlotW = 8;

    typedef logic [1:0] t_req;

    localparam t_req REQ_LOOKUP = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_CLEAR  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, reset accumulators
        logic rd_en;    // read directory entry at rd_addr
        logic upd;      // the read is part of the rank update sweep
        logic resolve;  // scan finished: decide eviction
        logic fin;      // write result, place new entry or clear
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan; // incoming request walks the directory
        logic skip_upd;   // lookup missed, no ranks change
    } t_sts;

endpackage

[rtl/lksc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_req_if / lksc_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface lksc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lksc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [7:0]  slot;
    logic        evicted;
    logic [31:0] evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, output ready);
endinterface

[rtl/lru_keyed_slot_cache_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache_top
// Fully associative directory with LRU replacement, one result per request.
// ----------------------------------------------------------------------------
// One request at a time. Lookup and insert each sweep the directory RAM
// twice, one entry per cycle: a scan (newest matching key, or LRU victim and
// lowest free slot) and a rank update written back behind the read; a lookup
// miss skips the second sweep, and clear and the unused code skip both. The
// single read port of the directory RAM is why each sweep takes one entry at
// a time. A finished result waits in an output register; the next request is
// taken meanwhile and only stalls at hand-off. Valid bits are flip-flops, so
// reset and clear are immediate and need no clearing pass. Slot numbers above
// 255 are truncated to 8 bits.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache_top import lksc_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lksc_req_if.sink  i_req,
    lksc_rsp_if.source o_rsp
);
    localparam int A = $clog2(ENTRIES);

    t_cmd         cmd;
    t_sts         sts;
    logic [A-1:0] rd_addr;

    // sequencer: handshakes and sweep addresses
    lksc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    // directory store and payload
    lksc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .o_sts         (sts),
        .o_hit         (o_rsp.hit),
        .o_slot        (o_rsp.slot),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );
endmodule

[rtl/lksc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lksc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/lksc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_datapath
// Directory store, valid bits, scan accumulators, rank update and result.
// ----------------------------------------------------------------------------
module lksc_datapath import lksc_pkg::*; #(
    parameter int ENTRIES = 256,
    localparam int A = $clog2(ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [A-1:0]    i_rd_addr,
    input  logic [1:0]      i_req_type,
    input  logic [KeyW-1:0] i_key,
    output t_sts            o_sts,
    output logic            o_hit,
    output logic [SlotW-1:0] o_slot,
    output logic            o_evicted,
    output logic [KeyW-1:0] o_evicted_key
);
    localparam int W = KeyW + 2 * A;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [A:0]         r_count, n_count;
    logic               r_p_vld, n_p_vld;
    logic               r_p_upd, n_p_upd;
    logic [A-1:0]       r_p_addr, n_p_addr;

    t_req               r_req, n_req;
    logic [KeyW-1:0]    r_key, n_key;
    logic               r_fnd, n_fnd;
    logic [A-1:0]       r_fidx, n_fidx, r_fir, n_fir, r_fur, n_fur;
    logic               r_mvld, n_mvld;
    logic [A-1:0]       r_midx, n_midx, r_mur, n_mur, r_mir, n_mir;
    logic [KeyW-1:0]    r_mkey, n_mkey;
    logic               r_freev, n_freev;
    logic [A-1:0]       r_free_idx, n_free_idx;
    logic               r_evict, n_evict;

    logic               r_hit, n_hit, r_ev, n_ev;
    logic [SlotW-1:0]   r_slot, n_slot;
    logic [KeyW-1:0]    r_evk, n_evk;

    logic               ram_we;
    logic [A-1:0]       ram_waddr;
    logic [W-1:0]       ram_wdata, ram_rdata;
    logic [KeyW-1:0]    rd_key;
    logic [A-1:0]       rd_ur, rd_ir, nur, nir, slot_i;
    logic               v;

    lksc_ram #(.WIDTH(W), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[W-1 -: KeyW];
    assign rd_ur  = ram_rdata[2*A-1 -: A];
    assign rd_ir  = ram_rdata[A-1:0];
    assign v      = r_valid[r_p_addr];
    assign slot_i = r_evict ? r_midx : r_free_idx;

    assign o_sts.needs_scan = (i_req_type == REQ_LOOKUP) || (i_req_type == REQ_INSERT);
    assign o_sts.skip_upd   = (r_req == REQ_LOOKUP) && !r_fnd;

    always_comb begin
        n_valid = r_valid;   n_count = r_count;
        n_p_vld = i_cmd.rd_en; n_p_upd = i_cmd.upd; n_p_addr = i_rd_addr;
        n_req = r_req;       n_key = r_key;
        n_fnd = r_fnd;       n_fidx = r_fidx; n_fir = r_fir; n_fur = r_fur;
        n_mvld = r_mvld;     n_midx = r_midx; n_mur = r_mur; n_mir = r_mir;
        n_mkey = r_mkey;     n_freev = r_freev; n_free_idx = r_free_idx;
        n_evict = r_evict;
        n_hit = r_hit;       n_slot = r_slot; n_ev = r_ev; n_evk = r_evk;
        ram_we = 1'b0;       ram_waddr = r_p_addr; ram_wdata = ram_rdata;
        nur = rd_ur;         nir = rd_ir;

        if (i_cmd.load) begin
            n_req = i_req_type; n_key = i_key;
            n_fnd = 1'b0; n_mvld = 1'b0; n_freev = 1'b0; n_evict = 1'b0;
        end

        // scan: newest matching key, or LRU victim and first free slot
        if (r_p_vld && !r_p_upd) begin
            if (r_req == REQ_LOOKUP) begin
                if (v && rd_key == r_key && (!r_fnd || rd_ir < r_fir)) begin
                    n_fnd = 1'b1; n_fidx = r_p_addr; n_fir = rd_ir; n_fur = rd_ur;
                end
            end else begin
                if (v && (!r_mvld || rd_ur > r_mur)) begin
                    n_mvld = 1'b1; n_midx = r_p_addr; n_mur = rd_ur;
                    n_mir = rd_ir; n_mkey = rd_key;
                end
                if (!v && !r_freev) begin
                    n_freev = 1'b1; n_free_idx = r_p_addr;
                end
            end
        end

        // rank update, written back behind the read
        if (r_p_vld && r_p_upd) begin
            if (r_req == REQ_LOOKUP) begin
                if (r_p_addr == r_fidx) begin
                    nur = '0;
                end else if (v && rd_ur < r_fur) begin
                    nur = rd_ur + A'(1);
                end
            end else if (v) begin
                nur = rd_ur + A'(1);
                // eviction closes the gap, the new entry opens one
                if (!(r_evict && rd_ir > r_mir)) begin
                    nir = rd_ir + A'(1);
                end
            end
            ram_we = 1'b1;
            ram_wdata = {rd_key, nur, nir};
        end

        if (i_cmd.resolve) begin
            if (r_req == REQ_INSERT && r_count == (A+1)'(ENTRIES)) begin
                n_evict = 1'b1;
                n_valid[r_midx] = 1'b0;
            end
        end

        if (i_cmd.fin) begin
            n_hit = 1'b0; n_slot = '0; n_ev = 1'b0; n_evk = '0;
            case (r_req)
                REQ_LOOKUP: begin
                    n_hit = r_fnd;
                    n_slot = r_fnd ? SlotW'(r_fidx) : '0;
                end
                REQ_INSERT: begin
                    n_hit = 1'b1;
                    n_slot = SlotW'(slot_i);
                    n_ev = r_evict;
                    n_evk = r_evict ? r_mkey : '0;
                    ram_we = 1'b1;
                    ram_waddr = slot_i;
                    ram_wdata = {r_key, {A{1'b0}}, {A{1'b0}}};
                    n_valid[slot_i] = 1'b1;
                    if (!r_evict) begin
                        n_count = r_count + (A+1)'(1);
                    end
                end
                REQ_CLEAR: begin
                    n_valid = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_p_vld <= n_p_vld;
        end
        r_p_upd <= n_p_upd;  r_p_addr <= n_p_addr;
        r_req <= n_req;      r_key <= n_key;
        r_fnd <= n_fnd;      r_fidx <= n_fidx; r_fir <= n_fir; r_fur <= n_fur;
        r_mvld <= n_mvld;    r_midx <= n_midx; r_mur <= n_mur; r_mir <= n_mir;
        r_mkey <= n_mkey;    r_freev <= n_freev; r_free_idx <= n_free_idx;
        r_evict <= n_evict;
        r_hit <= n_hit;      r_slot <= n_slot; r_ev <= n_ev; r_evk <= n_evk;
    end

    assign o_hit = r_hit;
    assign o_slot = r_slot;
    assign o_evicted = r_ev;
    assign o_evicted_key = r_evk;
endmodule

[rtl/lksc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_ctrl
// Sequencer: scan sweep, resolve, update sweep, result hand-off.
// ----------------------------------------------------------------------------
module lksc_ctrl import lksc_pkg::*; #(
    parameter int ENTRIES = 256,
    localparam int A = $clog2(ENTRIES)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    input  t_sts         i_sts,
    output t_cmd         o_cmd,
    output logic [A-1:0] o_rd_addr
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SDRN, S_RES, S_UPD, S_UDRN, S_FIN
    } t_state;

    t_state       r_state;
    logic [A-1:0] r_cnt;
    logic         r_out_vld;
    logic         out_free, last;

    assign out_free = !r_out_vld || i_out_ready;
    assign last     = (r_cnt == A'(ENTRIES - 1));

    always_comb begin
        o_cmd = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en   = (r_state == S_SCAN) || (r_state == S_UPD);
        o_cmd.upd     = (r_state == S_UPD);
        o_cmd.resolve = (r_state == S_RES);
        o_cmd.fin     = (r_state == S_FIN) && out_free;
    end

    assign o_rd_addr   = r_cnt;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= i_sts.needs_scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + A'(1);
                    if (last) begin
                        r_state <= S_SDRN;
                    end
                end
                S_SDRN: r_state <= S_RES;
                S_RES: begin
                    r_cnt <= '0;
                    r_state <= i_sts.skip_upd ? S_FIN : S_UPD;
                end
                S_UPD: begin
                    r_cnt <= r_cnt + A'(1);
                    if (last) begin
                        r_state <= S_UDRN;
                    end
                end
                S_UDRN: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/lksc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lksc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_hit,
    input logic [7:0]  i_slot,
    input logic        i_evicted,
    input logic [31:0] i_evicted_key
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_slot) && $stable(i_evicted_key))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_slot == 8'd0 && !i_evicted)
        else $error("miss with slot or eviction");

    a_evk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_evicted |-> i_evicted_key == 32'd0)
        else $error("evicted key without eviction");
endmodule

bind lru_keyed_slot_cache_top lksc_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_hit         (o_rsp.hit),
    .i_slot        (o_rsp.slot),
    .i_evicted     (o_rsp.evicted),
    .i_evicted_key (o_rsp.evicted_key)
);

[verif/lru_keyed_slot_cache_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache_top_tb
// Self-checking bench for the LRU keyed slot cache directory. Requests go in
// through a queue-fed driver with random gaps; results are checked field by
// field against an in-bench LRU directory model as they come out.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache_top_tb;
    import lksc_pkg::*;

    localparam int NENT = 256;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        t_req        req_type;
        logic [31:0] key;
    } t_item;

    typedef struct packed {
        logic        hit;
        logic [7:0]  slot;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lksc_req_if req_ch ();
    lksc_rsp_if rsp_ch ();

    lru_keyed_slot_cache_top #(.ENTRIES(NENT)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Directory model: keys, valid bits, recency and insertion ranks
    // ------------------------------------------------------------------
    logic [31:0] dir_key   [NENT];
    logic        dir_valid [NENT];
    int          dir_use   [NENT];
    int          dir_age   [NENT];
    int          dir_count;

    t_item pending_items[$];
    t_res  expected_results[$];
    int    mismatches = 0;
    bit    hold_sender = 1'b0;
    longint cycles = 0;
    logic [31:0] used_keys[$];

    function automatic t_res predict_directory(t_item it);
        t_res r;
        int found, victim, freeslot, rk, ia;
        r = '0;
        if (it.req_type == REQ_LOOKUP) begin
            found = -1;
            for (int i = 0; i < NENT; i++)
                if (dir_valid[i] && dir_key[i] == it.key)
                    if (found < 0 || dir_age[i] < dir_age[found]) found = i;
            if (found >= 0) begin
                rk = dir_use[found];
                for (int i = 0; i < NENT; i++)
                    if (dir_valid[i] && dir_use[i] < rk) dir_use[i]++;
                dir_use[found] = 0;
                r.hit = 1'b1;
                r.slot = found[7:0];
            end
        end else if (it.req_type == REQ_INSERT) begin
            victim = -1;
            if (dir_count >= NENT) begin
                for (int i = 0; i < NENT; i++)
                    if (dir_valid[i] && (victim < 0 || dir_use[i] > dir_use[victim]))
                        victim = i;
                ia = dir_age[victim];
                r.evicted = 1'b1;
                r.evicted_key = dir_key[victim];
                dir_valid[victim] = 1'b0;
                for (int i = 0; i < NENT; i++)
                    if (dir_valid[i] && dir_age[i] > ia) dir_age[i]--;
                dir_count--;
                freeslot = victim;
            end else begin
                freeslot = 0;
                for (int i = NENT - 1; i >= 0; i--)
                    if (!dir_valid[i]) freeslot = i;
            end
            for (int i = 0; i < NENT; i++)
                if (dir_valid[i]) begin
                    dir_use[i]++;
                    dir_age[i]++;
                end
            dir_key[freeslot] = it.key;
            dir_valid[freeslot] = 1'b1;
            dir_use[freeslot] = 0;
            dir_age[freeslot] = 0;
            dir_count++;
            r.hit = 1'b1;
            r.slot = freeslot[7:0];
        end else if (it.req_type == REQ_CLEAR) begin
            for (int i = 0; i < NENT; i++) dir_valid[i] = 1'b0;
            dir_count = 0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes the next queued item after a random gap
    // ------------------------------------------------------------------
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.key      <= '0;
        end else begin
            t_item nx;
            bit    fire;
            fire = req_ch.valid && req_ch.ready;
            if (fire)
                expected_results.push_back(predict_directory({req_ch.req_type, req_ch.key}));
            if (fire || !req_ch.valid) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0 && !hold_sender) begin
                    nx = pending_items.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= nx.req_type;
                    req_ch.key      <= nx.key;
                    drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare each result with the oldest
    // expectation
    // ------------------------------------------------------------------
    int mon_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            t_res got, exp_r;
            int   g;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted, rsp_ch.evicted_key};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp hit=%b slot=%0d ev=%b evk=%h,",
                                      " got hit=%b slot=%0d ev=%b evk=%h"},
                                     exp_r.hit, exp_r.slot, exp_r.evicted,
                                     exp_r.evicted_key, got.hit, got.slot,
                                     got.evicted, got.evicted_key);
                    end
                end
                g = $urandom_range(0, 4);
                mon_gap <= (g > 0) ? g - 1 : 0;
                rsp_ch.ready <= (g == 0);
            end else if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Timeout watch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_keyed_slot_cache_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key();
        // mostly reuse known keys so lookups hit and duplicates occur
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom();
    endfunction

    task automatic queue_item(t_req rq, logic [31:0] k);
        t_item it;
        it.req_type = rq;
        it.key = k;
        pending_items.push_back(it);
        if (rq == REQ_INSERT) begin
            used_keys.push_back(k);
            if (used_keys.size() > 400) void'(used_keys.pop_front());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || req_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n, r;
        for (int i = 0; i < NENT; i++) dir_valid[i] = 1'b0;
        dir_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: miss on empty, extreme keys, duplicates, clear, code 3
        queue_item(REQ_LOOKUP, 32'h0);
        queue_item(REQ_INSERT, 32'h0);
        queue_item(REQ_INSERT, 32'hFFFF_FFFF);
        queue_item(REQ_INSERT, 32'hFFFF_FFFF);
        queue_item(REQ_LOOKUP, 32'hFFFF_FFFF);
        queue_item(REQ_LOOKUP, 32'h0);
        queue_item(REQ_LOOKUP, 32'h1234_5678);
        queue_item(t_req'(2'd3), 32'hFFFF_FFFF);
        queue_item(REQ_CLEAR, 32'hFFFF_FFFF);
        queue_item(REQ_LOOKUP, 32'h0);
        queue_item(REQ_INSERT, 32'hA5A5_5A5A);
        queue_item(REQ_LOOKUP, 32'hA5A5_5A5A);

        // Pause until every result is back
        hold_sender = 1'b1;
        repeat (2) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();
        hold_sender = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;

        // Fill past capacity so eviction paths get exercised
        for (int i = 0; i < 300; i++) begin
            queue_item(REQ_INSERT, $urandom());
            if (i % 5 == 0) queue_item(REQ_LOOKUP, pick_key());
        end
        wait_drained();

        // Random mix
        n = 0;
        while (n < 880) begin
            r = $urandom_range(0, 99);
            if (r < 50)      queue_item(REQ_LOOKUP, pick_key());
            else if (r < 97) queue_item(REQ_INSERT, pick_key());
            else if (r < 99) queue_item(REQ_CLEAR, $urandom());
            else             queue_item(t_req'(2'd3), $urandom());
            n++;
            if (pending_items.size() > 16) wait_drained();
        end
        wait_drained();
        repeat (600) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("lru_keyed_slot_cache_top_tb OK");
        end else begin
            $display("lru_keyed_slot_cache_top_tb NOT OK");
        end
        $finish;
    end
endmodule
